@@ sv/spherical_shell_step_locator_assert.svh @@
// Assertion macros for the shell step locator.
// Needs clk and rst_n in scope where a macro is used.
`ifndef SPHERICAL_SHELL_STEP_LOCATOR_ASSERT_SVH
`define SPHERICAL_SHELL_STEP_LOCATOR_ASSERT_SVH

// Same-cycle implication, off while in reset
`define SSL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked through reset
`define SSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ssl_pkg.sv @@
// Shared types, boundary tables and constants for the shell step locator.
// No dependencies.
`timescale 1ns / 1ps

package ssl_pkg;

  localparam int NUM_SHELLS_DEF = 15;
  localparam int TABLE_LEN      = 16;
  localparam int GEO_IDX        = 14;
  localparam int ONE_METRE      = 16;
  localparam int SQRT_STAGES    = 32;
  localparam int LANES          = 4;
  localparam int LANE_R         = 0;
  localparam int LANE_UP        = 1;
  localparam int LANE_LO1       = 2;
  localparam int LANE_LO2       = 3;

  localparam logic signed [31:0] B_LIMIT    = 32'sh7FFF_FFFF;
  localparam logic [29:0]        RADIUS_MAX = '1;

  typedef logic [TABLE_LEN-1:0][31:0] bound_tab_t;
  typedef logic [TABLE_LEN-1:0][63:0] rsq_tab_t;

  // Boundary radii, 1/16 m, entry 0 innermost
  localparam bound_tab_t BOUND_R = {
    32'd1349248000, 32'd674624000, 32'd103536000, 32'd102576000,
    32'd102096000,  32'd102000000, 32'd101936000, 32'd101888000,
    32'd101696000,  32'd101545600, 32'd98416000,  32'd95536000,
    32'd92336000,   32'd91216000,  32'd55680000,  32'd19544000
  };

  // Squared radii, worked out at elaboration
  function automatic rsq_tab_t mk_rsq();
    rsq_tab_t t;
    for (int i = 0; i < TABLE_LEN; i++) begin
      t[i] = 64'(BOUND_R[i]) * 64'(BOUND_R[i]);
    end
    return t;
  endfunction

  localparam rsq_tab_t BOUND_RSQ = mk_rsq();

  typedef logic [LANES-1:0][63:0] ssl_ops_t;
  typedef logic [LANES-1:0][31:0] ssl_roots_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ssl_in_t;

  typedef struct packed {
    logic        inside_res;
    logic [3:0]  shell_index;
    logic [31:0] step_length;
    logic [29:0] radius;
  } ssl_out_t;

  // Per-item control carried alongside the root pipeline
  typedef struct packed {
    logic               in_geo;
    logic [3:0]         shell;
    logic signed [31:0] b;
    logic               lo1_en;
    logic               lo2_en;
  } ssl_side_t;

  localparam int SIDE_W = $bits(ssl_side_t);

endpackage

@@ sv/ssl_prep.sv @@
// Front end: products, squared radius, projection b, shell search and the
// three squared chord terms. Four register stages. Depends on ssl_pkg.
`timescale 1ns / 1ps

module ssl_prep import ssl_pkg::*; #(
  parameter int NUM_SHELLS = NUM_SHELLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  ssl_in_t   in_data,
  output logic      out_valid,
  output ssl_ops_t  out_op,
  output ssl_side_t out_side
);

  localparam int LAST_RAW = (NUM_SHELLS > TABLE_LEN - 1) ? TABLE_LEN - 1 : NUM_SHELLS;
  localparam int LAST     = (LAST_RAW < 1) ? 1 : LAST_RAW;

  logic [3:0] vld_r;

  // stage 1: squares and direction products
  logic [2:0][63:0]        sq_r, sq_nxt;
  logic signed [2:0][63:0] pr_r, pr_nxt;

  always_comb begin
    logic signed [2:0][31:0] p;
    logic signed [2:0][31:0] u;
    logic [31:0]             mag;
    p = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
    u = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
    for (int k = 0; k < 3; k++) begin
      mag       = p[k][31] ? 32'(-p[k]) : 32'(p[k]);
      sq_nxt[k] = 64'(mag) * 64'(mag);
      pr_nxt[k] = $signed(p[k]) * $signed(u[k]);
    end
  end

  // stage 2: r2 sum and b = floor(dot / 2^30), saturated
  logic [63:0]        r2_2_r, r2_2_nxt;
  logic signed [31:0] b_2_r, b_2_nxt;

  always_comb begin
    logic signed [65:0] dot;
    logic signed [35:0] bfull;
    r2_2_nxt = sq_r[0] + sq_r[1] + sq_r[2];
    dot      = 66'($signed(pr_r[0])) + 66'($signed(pr_r[1])) + 66'($signed(pr_r[2]));
    bfull    = dot[65:30];
    if (bfull > 36'(B_LIMIT)) begin
      b_2_nxt = B_LIMIT;
    end else if (bfull < -36'(B_LIMIT)) begin
      b_2_nxt = -B_LIMIT;
    end else begin
      b_2_nxt = bfull[31:0];
    end
  end

  // stage 3: shell search, outside test, b squared
  logic [63:0]        r2_3_r, bsq_3_r, bsq_3_nxt;
  logic signed [31:0] b_3_r;
  logic [3:0]         shell_3_r, shell_3_nxt;
  logic               inside_3_r, inside_3_nxt;

  always_comb begin
    logic [31:0] bmag;
    inside_3_nxt = (r2_2_r <= BOUND_RSQ[GEO_IDX]);
    shell_3_nxt  = 4'(LAST - 1);
    for (int k = LAST - 1; k >= 0; k--) begin
      if (r2_2_r <= BOUND_RSQ[k]) shell_3_nxt = 4'(k);
    end
    bmag      = b_2_r[31] ? 32'(-b_2_r) : 32'(b_2_r);
    bsq_3_nxt = 64'(bmag) * 64'(bmag);
  end

  // stage 4: squared chord lengths to the upper and lower boundaries
  ssl_ops_t  op_4_nxt;
  ssl_side_t side_4_nxt;

  always_comb begin
    logic [3:0]         idx_up, idx_lo1, idx_lo2;
    logic signed [65:0] d2_up, d2_lo1, d2_lo2;
    logic               pos_up, pos_lo1, pos_lo2;
    idx_up  = shell_3_r + 4'd1;
    idx_lo1 = (shell_3_r == 4'd0) ? 4'd0 : shell_3_r - 4'd1;
    idx_lo2 = (shell_3_r < 4'd2) ? 4'd0 : shell_3_r - 4'd2;
    d2_up   = $signed({2'b00, bsq_3_r}) + $signed({2'b00, BOUND_RSQ[idx_up]})
            - $signed({2'b00, r2_3_r});
    d2_lo1  = $signed({2'b00, bsq_3_r}) + $signed({2'b00, BOUND_RSQ[idx_lo1]})
            - $signed({2'b00, r2_3_r});
    d2_lo2  = $signed({2'b00, bsq_3_r}) + $signed({2'b00, BOUND_RSQ[idx_lo2]})
            - $signed({2'b00, r2_3_r});
    pos_up  = !d2_up[65]  && (d2_up  != '0);
    pos_lo1 = !d2_lo1[65] && (d2_lo1 != '0);
    pos_lo2 = !d2_lo2[65] && (d2_lo2 != '0);
    op_4_nxt[LANE_R]   = r2_3_r;
    op_4_nxt[LANE_UP]  = pos_up  ? d2_up[63:0]  : 64'd0;
    op_4_nxt[LANE_LO1] = pos_lo1 ? d2_lo1[63:0] : 64'd0;
    op_4_nxt[LANE_LO2] = pos_lo2 ? d2_lo2[63:0] : 64'd0;
    side_4_nxt.in_geo  = inside_3_r;
    side_4_nxt.shell   = shell_3_r;
    side_4_nxt.b       = b_3_r;
    side_4_nxt.lo1_en  = (shell_3_r != 4'd0) && b_3_r[31] && pos_lo1;
    side_4_nxt.lo2_en  = (shell_3_r > 4'd1) && b_3_r[31] && pos_lo2;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r       <= sq_nxt;
      pr_r       <= pr_nxt;
      r2_2_r     <= r2_2_nxt;
      b_2_r      <= b_2_nxt;
      r2_3_r     <= r2_2_r;
      b_3_r      <= b_2_r;
      bsq_3_r    <= bsq_3_nxt;
      shell_3_r  <= shell_3_nxt;
      inside_3_r <= inside_3_nxt;
      out_op     <= op_4_nxt;
      out_side   <= side_4_nxt;
    end
  end

  assign out_valid = vld_r[3];

endmodule

@@ sv/ssl_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage, several lanes
// side by side with a sideband word. Depends on ssl_pkg.
`timescale 1ns / 1ps

module ssl_sqrt_pipe import ssl_pkg::*; #(
  parameter int NLANES = LANES,
  parameter int SW     = SIDE_W
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [NLANES-1:0][63:0]      in_op,
  input  logic [SW-1:0]                in_side,
  output logic                         out_valid,
  output logic [NLANES-1:0][31:0]      out_root,
  output logic [SW-1:0]                out_side
);

  localparam int STAGES = SQRT_STAGES;

  logic [NLANES-1:0][63:0] v_r   [STAGES];
  logic [NLANES-1:0][63:0] res_r [STAGES];
  logic [NLANES-1:0][63:0] v_src [STAGES];
  logic [NLANES-1:0][63:0] res_src [STAGES];
  logic [NLANES-1:0][63:0] v_nxt [STAGES];
  logic [NLANES-1:0][63:0] res_nxt [STAGES];
  logic [SW-1:0]           side_r [STAGES];
  logic [STAGES-1:0]       vld_r;

  // stage inputs
  always_comb begin
    v_src[0]   = in_op;
    res_src[0] = '0;
    for (int s = 1; s < STAGES; s++) begin
      v_src[s]   = v_r[s-1];
      res_src[s] = res_r[s-1];
    end
  end

  // one trial subtraction per stage and lane, trial bit 4^(31-s)
  always_comb begin
    logic [63:0] bitv;
    logic [64:0] trial;
    for (int s = 0; s < STAGES; s++) begin
      bitv = 64'd1 << (62 - 2 * s);
      for (int l = 0; l < NLANES; l++) begin
        trial = {1'b0, res_src[s][l]} + {1'b0, bitv};
        if ({1'b0, v_src[s][l]} >= trial) begin
          v_nxt[s][l]   = v_src[s][l] - trial[63:0];
          res_nxt[s][l] = (res_src[s][l] >> 1) + bitv;
        end else begin
          v_nxt[s][l]   = v_src[s][l];
          res_nxt[s][l] = res_src[s][l] >> 1;
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      v_r       <= v_nxt;
      res_r     <= res_nxt;
      side_r[0] <= in_side;
      for (int s = 1; s < STAGES; s++) begin
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      out_root[l] = res_r[STAGES-1][l][31:0];
    end
  end

endmodule

@@ sv/ssl_finish.sv @@
// Back end: boundary distances, minimum, clamps and the output register.
// Two register stages. Depends on ssl_pkg.
`timescale 1ns / 1ps

module ssl_finish import ssl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  ssl_roots_t in_root,
  input  ssl_side_t  in_side,
  output logic       out_valid,
  output ssl_out_t   out_data
);

  // stage 1: distance = d - b - 1 m for each boundary
  logic               f1_vld_r;
  logic signed [34:0] dup_r, dlo1_r, dlo2_r;
  logic signed [34:0] dup_nxt, dlo1_nxt, dlo2_nxt;
  logic               lo1_en_r, lo2_en_r, inside_r;
  logic [3:0]         shell_r;
  logic [29:0]        radius_r, radius_nxt;

  always_comb begin
    logic signed [34:0] bx;
    bx       = 35'(in_side.b) + 35'(ONE_METRE);
    dup_nxt  = $signed({3'b000, in_root[LANE_UP]})  - bx;
    dlo1_nxt = $signed({3'b000, in_root[LANE_LO1]}) - bx;
    dlo2_nxt = $signed({3'b000, in_root[LANE_LO2]}) - bx;
    radius_nxt = (in_root[LANE_R] > 32'(RADIUS_MAX)) ? RADIUS_MAX
                                                     : in_root[LANE_R][29:0];
  end

  // stage 2: minimum over candidates and clamps
  ssl_out_t out_nxt;

  always_comb begin
    logic signed [34:0] step;
    step = dup_r;
    if (lo1_en_r && (dlo1_r < step)) step = dlo1_r;
    if (lo2_en_r && (dlo2_r < step)) step = dlo2_r;
    if (step < 35'(ONE_METRE)) step = 35'(ONE_METRE);
    if (step > $signed({3'b000, 32'hFFFF_FFFF})) step = $signed({3'b000, 32'hFFFF_FFFF});
    out_nxt.radius = radius_r;
    if (inside_r) begin
      out_nxt.inside_res  = 1'b1;
      out_nxt.shell_index = shell_r;
      out_nxt.step_length = step[31:0];
    end else begin
      out_nxt.inside_res  = 1'b0;
      out_nxt.shell_index = 4'd0;
      out_nxt.step_length = 32'd0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1_vld_r  <= in_valid;
      out_valid <= f1_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      dup_r    <= dup_nxt;
      dlo1_r   <= dlo1_nxt;
      dlo2_r   <= dlo2_nxt;
      lo1_en_r <= in_side.lo1_en;
      lo2_en_r <= in_side.lo2_en;
      inside_r <= in_side.in_geo;
      shell_r  <= in_side.shell;
      radius_r <= radius_nxt;
      out_data <= out_nxt;
    end
  end

endmodule

@@ sv/spherical_shell_step_locator.sv @@
// Channel  Dir  Payload     Transfer when
// in_      in   ssl_in_t    in_valid && !in_stall
// out_     out  ssl_out_t   out_valid && !out_stall
//
// One item per cycle unless a held result stalls the pipeline; 4 front
// stages, 32 square-root stages and 2 back stages lie between input and result.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// The whole pipeline holds while a result sits in the output register under
// stall; otherwise a new item is taken every cycle, bubbles included.
// Depends on ssl_pkg, ssl_prep, ssl_sqrt_pipe, ssl_finish.
`timescale 1ns / 1ps

`include "spherical_shell_step_locator_assert.svh"

module spherical_shell_step_locator import ssl_pkg::*; #(
  parameter int NUM_SHELLS = NUM_SHELLS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ssl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ssl_out_t out_data
);

  logic       en;
  logic       pre_valid, sq_valid;
  ssl_ops_t   pre_op;
  ssl_side_t  pre_side, sq_side;
  ssl_roots_t sq_root;

  // global advance: blocked only by a held result
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ssl_prep #(.NUM_SHELLS(NUM_SHELLS)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (pre_valid),
    .out_op    (pre_op),
    .out_side  (pre_side)
  );

  ssl_sqrt_pipe #(.NLANES(LANES), .SW(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pre_valid),
    .in_op     (pre_op),
    .in_side   (pre_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  ssl_finish u_finish (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // checks
  `SSL_ASSERT_IMPL(a_outside_zero, out_valid && !out_data.inside_res, (out_data.shell_index == 4'd0) && (out_data.step_length == 32'd0), "outside result not cleared")
  `SSL_ASSERT_IMPL(a_inside_sane, out_valid && out_data.inside_res, (out_data.step_length >= 32'(ONE_METRE)) && (out_data.radius <= BOUND_R[GEO_IDX][29:0]), "inside result out of range")
  `SSL_ASSERT_IMPL(a_hold_on_stall, out_valid && out_stall, in_stall, "input taken while result held")
  `SSL_ASSERT_NEXT(a_reset_clears, !rst_n, !out_valid && !in_stall, "pipeline not cleared by reset")

endmodule
